[rtl/core/srsm_pkg.sv]
// Shared constants and controller/datapath interface types for the scatter merge unit.
package srsm_pkg;

	localparam int unsigned DEF_MAX_ROWS    = 1024;
	localparam int unsigned DEF_MAX_ENTRIES = 4096;

	localparam int unsigned ROW_W = 10;
	localparam int unsigned POS_W = 12;
	localparam int unsigned COL_W = 31;
	localparam int unsigned PAY_W = 64;
	localparam int unsigned RR_W  = 11;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 11;

	localparam logic [CFG_IDX_W-1:0] REG_RESULT_ROWS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CARRY_VALUES = 2'd1;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_PULL = 1'b1;

	typedef struct packed {
		logic clr_wr;
		logic ld_store;
		logic ld_cnt_wr;
		logic drop_set;
		logic idx_rst;
		logic sum_rd;
		logic sum_wr;
		logic sc_rd;
		logic sc_fill_rd;
		logic sc_wr;
		logic sort_fin;
		logic em_ord_rd;
		logic em_ent_rd;
		logic em_out;
		logic done_out;
		logic batch_clr;
	} cmd_t;

	typedef struct packed {
		logic row_last;
		logic sc_end;
		logic em_have;
		logic load_ok;
		logic sorting;
		logic out_busy;
	} status_t;

endpackage

[rtl/core/sparse_row_scatter_merge_unit.sv]
// Top level of the sparse row scatter merge unit: a stable counting sort into row order.
// Loads store one entry each; a result word is held until taken and
// no input word is accepted meanwhile. Each pull with an entry left reads the order table
// and then the entry stores, all single-port memories. The first pull of a batch first runs
// the prefix sum over the row count memory, one row at a time across all MAX_ROWS rows,
// and then the scatter over each stored entry. After reset a clearing pass over all MAX_ROWS rows
// zeroes the row count memory before the first word is accepted; configuration writes
// are taken at any time.
module sparse_row_scatter_merge_unit #(
	parameter int unsigned MAX_ROWS    = srsm_pkg::DEF_MAX_ROWS,
	parameter int unsigned MAX_ENTRIES = srsm_pkg::DEF_MAX_ENTRIES
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [srsm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [srsm_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            operation,
	input  logic [srsm_pkg::ROW_W-1:0]      dest_row,
	input  logic [srsm_pkg::COL_W-1:0]      column,
	input  logic [srsm_pkg::PAY_W-1:0]      payload,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [srsm_pkg::ROW_W-1:0]      out_row,
	output logic [srsm_pkg::POS_W-1:0]      out_position,
	output logic [srsm_pkg::COL_W-1:0]      out_column,
	output logic [srsm_pkg::PAY_W-1:0]      out_payload,
	output logic                            done_res,
	output logic                            dropped
);
	import srsm_pkg::*;

	cmd_t    cmd;
	status_t sts;

	assign cfg_ready = 1'b1;

	srsm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.sts       (sts),
		.cmd       (cmd)
	);

	srsm_dp #(
		.MAX_ROWS    (MAX_ROWS),
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.dest_row     (dest_row),
		.column       (column),
		.payload      (payload),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_row      (out_row),
		.out_position (out_position),
		.out_column   (out_column),
		.out_payload  (out_payload),
		.done_res     (done_res),
		.dropped      (dropped)
	);

endmodule

[rtl/core/srsm_ctrl.sv]
// Sequencing state machine for loads, the sort passes and the emit steps.
module srsm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             operation,
	input  srsm_pkg::status_t sts,
	output srsm_pkg::cmd_t   cmd
);
	import srsm_pkg::*;

	localparam logic [3:0] ST_CLR     = 4'd0;
	localparam logic [3:0] ST_IDLE    = 4'd1;
	localparam logic [3:0] ST_LD      = 4'd2;
	localparam logic [3:0] ST_SUM_RD  = 4'd3;
	localparam logic [3:0] ST_SUM_WR  = 4'd4;
	localparam logic [3:0] ST_SC_RD   = 4'd5;
	localparam logic [3:0] ST_SC_FILL = 4'd6;
	localparam logic [3:0] ST_SC_WR   = 4'd7;
	localparam logic [3:0] ST_EM_ORD  = 4'd8;
	localparam logic [3:0] ST_EM_ENT  = 4'd9;

	logic [3:0] state_q, state_d;
	logic       accept;

	assign in_stall = (state_q != ST_IDLE) || sts.out_busy;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_CLR: begin
				cmd.clr_wr = 1'b1;
				if (sts.row_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept && operation == OP_LOAD) begin
					if (sts.load_ok) begin
						cmd.ld_store = 1'b1;
						state_d      = ST_LD;
					end else begin
						cmd.drop_set = 1'b1;
					end
				end else if (accept && operation == OP_PULL) begin
					if (!sts.sorting) begin
						cmd.idx_rst = 1'b1;
						state_d     = ST_SUM_RD;
					end else if (sts.em_have) begin
						cmd.em_ord_rd = 1'b1;
						state_d       = ST_EM_ORD;
					end else begin
						cmd.done_out  = 1'b1;
						cmd.batch_clr = 1'b1;
					end
				end
			end
			ST_LD: begin
				cmd.ld_cnt_wr = 1'b1;
				state_d       = ST_IDLE;
			end
			ST_SUM_RD: begin
				cmd.sum_rd = 1'b1;
				state_d    = ST_SUM_WR;
			end
			ST_SUM_WR: begin
				cmd.sum_wr = 1'b1;
				if (sts.row_last) begin
					cmd.idx_rst = 1'b1;
					state_d     = ST_SC_RD;
				end else begin
					state_d = ST_SUM_RD;
				end
			end
			ST_SC_RD: begin
				if (sts.sc_end) begin
					cmd.sort_fin = 1'b1;
					if (sts.em_have) begin
						cmd.em_ord_rd = 1'b1;
						state_d       = ST_EM_ORD;
					end else begin
						cmd.done_out  = 1'b1;
						cmd.batch_clr = 1'b1;
						state_d       = ST_IDLE;
					end
				end else begin
					cmd.sc_rd = 1'b1;
					state_d   = ST_SC_FILL;
				end
			end
			ST_SC_FILL: begin
				cmd.sc_fill_rd = 1'b1;
				state_d        = ST_SC_WR;
			end
			ST_SC_WR: begin
				cmd.sc_wr = 1'b1;
				state_d   = ST_SC_RD;
			end
			ST_EM_ORD: begin
				cmd.em_ent_rd = 1'b1;
				state_d       = ST_EM_ENT;
			end
			ST_EM_ENT: begin
				cmd.em_out = 1'b1;
				state_d    = ST_IDLE;
			end
			default: state_d = ST_CLR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLR;
		else state_q <= state_d;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> state_q == ST_IDLE && !sts.out_busy)
		else $error("word accepted outside idle");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EM_ENT |=> state_q == ST_IDLE && sts.out_busy)
		else $error("emit step did not present a result");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LD |-> $past(state_q) == ST_IDLE)
		else $error("count update without a load");

endmodule

[rtl/core/srsm_dp.sv]
// Entry stores, order table, row count and fill memories, counters and the result register.
module srsm_dp #(
	parameter int unsigned MAX_ROWS    = srsm_pkg::DEF_MAX_ROWS,
	parameter int unsigned MAX_ENTRIES = srsm_pkg::DEF_MAX_ENTRIES
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  srsm_pkg::cmd_t                  cmd,
	output srsm_pkg::status_t               sts,
	input  logic                            cfg_valid,
	input  logic [srsm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [srsm_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic [srsm_pkg::ROW_W-1:0]      dest_row,
	input  logic [srsm_pkg::COL_W-1:0]      column,
	input  logic [srsm_pkg::PAY_W-1:0]      payload,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [srsm_pkg::ROW_W-1:0]      out_row,
	output logic [srsm_pkg::POS_W-1:0]      out_position,
	output logic [srsm_pkg::COL_W-1:0]      out_column,
	output logic [srsm_pkg::PAY_W-1:0]      out_payload,
	output logic                            done_res,
	output logic                            dropped
);
	import srsm_pkg::*;

	localparam int unsigned RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int unsigned EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

	logic [COL_W-1:0] col_mem [MAX_ENTRIES];
	logic [PAY_W-1:0] pay_mem [MAX_ENTRIES];
	logic [ROW_W-1:0] row_mem [MAX_ENTRIES];
	logic [EW-1:0]    ord_mem [MAX_ENTRIES];
	logic [CW-1:0]    cnt_mem [MAX_ROWS];
	logic [CW-1:0]    fill_mem [MAX_ROWS];

	logic [RR_W-1:0]  result_rows_q;
	logic             carry_q;
	logic [CW-1:0]    total_q, cursor_q, scan_q, sum_q;
	logic [RW-1:0]    row_idx_q, ld_row_q;
	logic             sorting_q, drop_q;

	logic [COL_W-1:0] col_rd_q;
	logic [PAY_W-1:0] pay_rd_q;
	logic [ROW_W-1:0] row_rd_q;
	logic [EW-1:0]    ord_rd_q;
	logic [CW-1:0]    cnt_rd_q, fill_rd_q;

	logic [31:0]      limit;
	logic [RW-1:0]    cnt_addr, in_row_idx, rd_row_idx;
	logic [EW-1:0]    ent_addr;
	logic             row_last;

	assign limit      = (32'(result_rows_q) < MAX_ROWS) ? 32'(result_rows_q) : MAX_ROWS;
	assign in_row_idx = RW'(dest_row);
	assign rd_row_idx = RW'(row_rd_q);
	assign row_last   = (32'(row_idx_q) == MAX_ROWS - 1);

	assign sts.row_last = row_last;
	assign sts.sc_end   = (scan_q == total_q);
	assign sts.em_have  = (cursor_q < total_q);
	assign sts.load_ok  = !sorting_q && (32'(total_q) < MAX_ENTRIES)
		&& (32'(dest_row) < limit);
	assign sts.sorting  = sorting_q;
	assign sts.out_busy = out_valid;

	assign cnt_addr = cmd.ld_store ? in_row_idx : row_idx_q;
	assign ent_addr = cmd.em_ent_rd ? ord_rd_q : EW'(scan_q);

	always_ff @(posedge clk) begin
		if (cmd.ld_store) begin
			col_mem[EW'(total_q)] <= column;
			pay_mem[EW'(total_q)] <= carry_q ? payload : '0;
			row_mem[EW'(total_q)] <= dest_row;
		end
		if (cmd.sc_rd || cmd.em_ent_rd) begin
			col_rd_q <= col_mem[ent_addr];
			pay_rd_q <= pay_mem[ent_addr];
			row_rd_q <= row_mem[ent_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_wr || cmd.sum_wr) cnt_mem[row_idx_q] <= '0;
		else if (cmd.ld_cnt_wr) cnt_mem[ld_row_q] <= cnt_rd_q + 1'b1;
		if (cmd.ld_store || cmd.sum_rd) cnt_rd_q <= cnt_mem[cnt_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.sum_wr) fill_mem[row_idx_q] <= sum_q;
		else if (cmd.sc_wr) fill_mem[rd_row_idx] <= fill_rd_q + 1'b1;
		if (cmd.sc_fill_rd) fill_rd_q <= fill_mem[rd_row_idx];
	end

	always_ff @(posedge clk) begin
		if (cmd.sc_wr) ord_mem[EW'(fill_rd_q)] <= EW'(scan_q);
		if (cmd.em_ord_rd) ord_rd_q <= ord_mem[EW'(cursor_q)];
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_store) ld_row_q <= in_row_idx;
		if (cmd.em_out || cmd.done_out) begin
			out_row      <= cmd.em_out ? row_rd_q : '0;
			out_position <= cmd.em_out ? POS_W'(cursor_q) : '0;
			out_column   <= cmd.em_out ? col_rd_q : '0;
			out_payload  <= cmd.em_out ? pay_rd_q : '0;
			done_res     <= cmd.done_out;
			dropped      <= drop_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_rows_q <= '0;
			carry_q       <= 1'b1;
			total_q       <= '0;
			cursor_q      <= '0;
			scan_q        <= '0;
			sum_q         <= '0;
			row_idx_q     <= '0;
			sorting_q     <= 1'b0;
			drop_q        <= 1'b0;
			out_valid     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_index == REG_RESULT_ROWS) result_rows_q <= cfg_data;
			if (cfg_valid && cfg_index == REG_CARRY_VALUES) carry_q <= cfg_data[0];
			if (cmd.ld_store) total_q <= total_q + 1'b1;
			if (cmd.drop_set) drop_q <= 1'b1;
			if (cmd.idx_rst) begin
				row_idx_q <= '0;
				scan_q    <= '0;
				sum_q     <= '0;
			end else if (cmd.clr_wr || cmd.sum_wr) begin
				row_idx_q <= row_last ? '0 : row_idx_q + 1'b1;
			end
			if (cmd.sum_wr) sum_q <= sum_q + cnt_rd_q;
			if (cmd.sc_wr) scan_q <= scan_q + 1'b1;
			if (cmd.sort_fin) begin
				sorting_q <= 1'b1;
				cursor_q  <= '0;
			end
			if (cmd.em_out) cursor_q <= cursor_q + 1'b1;
			if (cmd.batch_clr) begin
				total_q   <= '0;
				cursor_q  <= '0;
				sorting_q <= 1'b0;
				drop_q    <= 1'b0;
			end
			if (cmd.em_out || cmd.done_out) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.em_out |-> cursor_q < total_q)
		else $error("emit beyond stored entries");
	assert property (@(posedge clk) disable iff (!arst_n)
		32'(total_q) <= MAX_ENTRIES && cursor_q <= total_q)
		else $error("entry counters out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sc_wr |-> 32'(fill_rd_q) < MAX_ENTRIES)
		else $error("scatter slot out of range");

endmodule
